[hw/rtl/ptts_pkg.sv]
// Shared constants and types for the periodic task tick scheduler.
// Used by ptts_cell and periodic_task_tick_scheduler_core; no dependencies.
package ptts_pkg;

  localparam int NUM_TASKS   = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  localparam int OPCODE_W    = 2;
  localparam int FIELD_W     = 16;
  localparam int TASK_IDX_W  = 3;
  localparam int MASK_W      = 8;

  localparam logic [OPCODE_W-1:0] OP_ADD      = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DISPATCH = 2'd2;

  typedef struct packed {
    logic                   add;
    logic                   tick;
    logic                   dispatch;
    logic [COUNT_WIDTH-1:0] period;
    logic [COUNT_WIDTH-1:0] offset;
  } cell_ctrl_t;

  typedef struct packed {
    logic add_hit;
    logic fired;
    logic sel;
    logic ready_left;
  } cell_stat_t;

endpackage

[hw/rtl/periodic_task_tick_scheduler_core.sv]
// Top level of the periodic task tick scheduler: a chain of ptts_cell slots
// with the command handshake and the registered result port. Depends on ptts_pkg.
//
// Add and tick each give one registered result: the item is accepted while busy is low and
// its single result appears with strobe high on the next cycle. A dispatch that
// finds n ready tasks gives n results on consecutive cycles, lowest index first,
// holding busy high after acceptance until the last ready task is picked, since the lowest-ready pick
// that ripples along the cell chain names one task per cycle. A dispatch with no
// ready task, like add and tick, gives one result the next cycle. Every result is
// shown for exactly one cycle and the receiver cannot stall it.
module periodic_task_tick_scheduler_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [ptts_pkg::OPCODE_W-1:0]      opcode,
  input  logic [ptts_pkg::FIELD_W-1:0]       period,
  input  logic [ptts_pkg::FIELD_W-1:0]       start_offset,
  output logic                               strobe,
  output logic [ptts_pkg::TASK_IDX_W-1:0]    task_index,
  output logic                               rejected,
  output logic                               task_ready,
  output logic [ptts_pkg::MASK_W-1:0]        fired_mask,
  output logic                               last
);
  import ptts_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DISP = 1'b1;

  logic                  state;
  logic                  state_next;
  logic                  accept;
  cell_ctrl_t            ctrl;
  cell_stat_t            stat [NUM_TASKS];
  logic [NUM_TASKS:0]    free_chain;
  logic [NUM_TASKS:0]    none_chain;
  logic [IDX_W-1:0]      add_idx;
  logic [IDX_W-1:0]      sel_idx;
  logic [NUM_TASKS-1:0]  fired;
  logic                  more_left;
  logic                  any_ready;

  logic                  strobe_next;
  logic [TASK_IDX_W-1:0] task_index_next;
  logic                  rejected_next;
  logic                  task_ready_next;
  logic [MASK_W-1:0]     fired_mask_next;
  logic                  last_next;

  assign busy   = (state == S_DISP);
  assign accept = start & ~busy;

  assign ctrl.add      = accept & (opcode == OP_ADD);
  assign ctrl.tick     = accept & (opcode == OP_TICK);
  assign ctrl.dispatch = (accept & (opcode == OP_DISPATCH)) | busy;
  assign ctrl.period   = COUNT_WIDTH'(period);
  assign ctrl.offset   = COUNT_WIDTH'(start_offset);

  assign free_chain[0] = 1'b1;
  assign none_chain[0] = 1'b1;

  for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
    ptts_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .free_in  (free_chain[g]),
      .free_out (free_chain[g+1]),
      .none_in  (none_chain[g]),
      .none_out (none_chain[g+1]),
      .stat     (stat[g])
    );
  end

  assign any_ready = ~none_chain[NUM_TASKS];

  always_comb begin
    add_idx   = '0;
    sel_idx   = '0;
    fired     = '0;
    more_left = 1'b0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (stat[i].add_hit) add_idx = IDX_W'(i);
      if (stat[i].sel) sel_idx = IDX_W'(i);
      fired[i]  = stat[i].fired;
      more_left = more_left | stat[i].ready_left;
    end
    fired_mask_next = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i < NUM_TASKS) fired_mask_next[i] = fired[i];
    end
  end

  always_comb begin
    state_next      = S_IDLE;
    strobe_next     = 1'b0;
    task_index_next = '0;
    rejected_next   = 1'b0;
    task_ready_next = 1'b0;
    last_next       = 1'b1;
    if (ctrl.dispatch) begin
      strobe_next = 1'b1;
      if (any_ready) begin
        task_index_next = TASK_IDX_W'(sel_idx);
        task_ready_next = 1'b1;
        last_next       = ~more_left;
        state_next      = more_left ? S_DISP : S_IDLE;
      end
    end else if (ctrl.add) begin
      strobe_next = 1'b1;
      if (free_chain[NUM_TASKS]) begin
        rejected_next = 1'b1;
      end else begin
        task_index_next = TASK_IDX_W'(add_idx);
      end
    end else if (ctrl.tick) begin
      strobe_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    task_index <= task_index_next;
    rejected   <= rejected_next;
    task_ready <= task_ready_next;
    fired_mask <= ctrl.tick ? fired_mask_next : '0;
    last       <= last_next;
  end

endmodule

[hw/rtl/ptts_cell.sv]
// One task slot of the scheduler chain: period, countdown, ready flag, valid.
// Depends on ptts_pkg; neighbors pass the fill and lowest-ready chains.
module ptts_cell (
  input  logic                clk,
  input  logic                rst,
  input  ptts_pkg::cell_ctrl_t ctrl,
  input  logic                free_in,
  output logic                free_out,
  input  logic                none_in,
  output logic                none_out,
  output ptts_pkg::cell_stat_t stat
);
  import ptts_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] period;
  logic [COUNT_WIDTH-1:0] countdown;
  logic                   expire;
  logic                   sel;

  assign free_out = free_in & valid;
  assign expire   = (countdown <= COUNT_WIDTH'(1));
  assign sel      = valid & ready & none_in;
  assign none_out = none_in & ~(valid & ready);

  assign stat.add_hit    = ctrl.add & free_in & ~valid;
  assign stat.fired      = ctrl.tick & valid & expire;
  assign stat.sel        = sel;
  assign stat.ready_left = valid & ready & ~(sel & ctrl.dispatch);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      ready <= 1'b0;
    end else if (stat.add_hit) begin
      valid <= 1'b1;
      ready <= 1'b0;
    end else if (stat.fired) begin
      ready <= 1'b1;
    end else if (ctrl.dispatch && sel) begin
      ready <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.add_hit) begin
      period    <= ctrl.period;
      countdown <= (ctrl.offset != '0) ? ctrl.offset : ctrl.period;
    end else if (ctrl.tick && valid) begin
      countdown <= expire ? period : countdown - COUNT_WIDTH'(1);
    end
  end

endmodule
